@@ rtl/core/ilide_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine package
// Request kinds, status codes, sequencer states and word constants shared by
// the list engine and its entry store.
// ----------------------------------------------------------------------------
`default_nettype none

package ilide_pkg;

   localparam int WORD_W  = 32;
   localparam int KIND_W  = 3;
   localparam int INDEX_W = 6;
   localparam int FOUND_W = 7;
   localparam int COUNT_W = 7;

   localparam logic signed [FOUND_W-1:0] NOT_FOUND = -7'sd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 3'd0,
      KIND_WRITE  = 3'd1,
      KIND_PUSH   = 3'd2,
      KIND_INSERT = 3'd3,
      KIND_DELETE = 3'd4,
      KIND_REMOVE = 3'd5,
      KIND_FIND   = 3'd6,
      KIND_POP    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/ilide_ram.sv @@
// ----------------------------------------------------------------------------
// Indexed list entry store
// Single-port-write, single-port-read word memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilide_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [ilide_pkg::WORD_W-1:0]   wr_data,
   input  wire logic                           rd_en,
   input  wire logic [AW-1:0]                  rd_addr,
   output logic      [ilide_pkg::WORD_W-1:0]   rd_data
);

   logic [ilide_pkg::WORD_W-1:0] mem [DEPTH];
   logic [ilide_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/indexed_list_insert_delete_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Indexed list insert/delete engine
// Fixed-capacity ordered list of signed words with a live count, served by
// a small sequencer that walks the entry memory one word per cycle.
// ----------------------------------------------------------------------------
// Each request takes one transfer in and returns one transfer out. Write,
// push and every rejected request go straight to the result. Read and pop
// read their one entry through the memory read port. Insert, delete, remove
// and find walk the affected entries through the single memory read port
// and write port, one entry per cycle; the number of entries walked is at
// most CAPACITY. The block holds req_stall high after acceptance until its
// result transfer completes.
`default_nettype none

module indexed_list_insert_delete_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic        [ilide_pkg::KIND_W-1:0]         req_kind,
   input  wire logic        [ilide_pkg::INDEX_W-1:0]        req_index,
   input  wire logic signed [ilide_pkg::WORD_W-1:0]         req_value,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic signed      [ilide_pkg::WORD_W-1:0]         rsp_read_value,
   output logic signed      [ilide_pkg::FOUND_W-1:0]        rsp_found_index,
   output logic             [ilide_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic             [1:0]                           rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   ilide_pkg::state_type  state_ff, state_in;
   ilide_pkg::kind_type   kind_ff, kind_in;
   ilide_pkg::status_type status_ff, status_in;
   logic [AW-1:0]                           idx_ff, idx_in;
   logic [ilide_pkg::WORD_W-1:0]            val_ff, val_in;
   logic [AW-1:0]                           ptr_ff, ptr_in;
   logic [AW-1:0]                           end_ff, end_in;
   logic                                    desc_ff, desc_in;
   logic                                    issue_ff, issue_in;
   logic                                    pv_ff, pv_in;
   logic [AW-1:0]                           paddr_ff, paddr_in;
   logic [CW-1:0]                           j_ff, j_in;
   logic [CW-1:0]                           count_ff, count_in;
   logic [ilide_pkg::WORD_W-1:0]            rdval_ff, rdval_in;
   logic signed [ilide_pkg::FOUND_W-1:0]    found_ff, found_in;

   logic                                    wr_en;
   logic [AW-1:0]                           wr_addr;
   logic [ilide_pkg::WORD_W-1:0]            wr_data;
   logic                                    rd_en;
   logic [ilide_pkg::WORD_W-1:0]            rd_data;

   logic                                    in_range;
   logic                                    full;
   logic [AW-1:0]                           last_addr;
   ilide_pkg::kind_type                     req_kind_t;

   ilide_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign req_kind_t = ilide_pkg::kind_type'(req_kind);
   assign in_range   = 32'(req_index) < 32'(count_ff);
   assign full       = count_ff == CW'(CAPACITY);
   assign last_addr  = AW'(count_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ilide_pkg::ST_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      desc_ff   <= desc_in;
      paddr_ff  <= paddr_in;
      j_ff      <= j_in;
      rdval_ff  <= rdval_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      desc_in   = desc_ff;
      issue_in  = issue_ff;
      pv_in     = pv_ff;
      paddr_in  = paddr_ff;
      j_in      = j_ff;
      count_in  = count_ff;
      rdval_in  = rdval_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = val_ff;
      rd_en     = 1'b0;

      unique case (state_ff)
         ilide_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind_t;
               idx_in    = AW'(req_index);
               val_in    = req_value;
               status_in = ilide_pkg::STATUS_OK;
               rdval_in  = '0;
               found_in  = ilide_pkg::NOT_FOUND;
               j_in      = '0;
               pv_in     = 1'b0;
               issue_in  = 1'b0;
               desc_in   = 1'b0;
               ptr_in    = AW'(req_index);
               end_in    = last_addr;
               state_in  = ilide_pkg::ST_DONE;
               unique case (req_kind_t)
                  ilide_pkg::KIND_READ: begin
                     if (!in_range) begin
                        status_in = ilide_pkg::STATUS_RANGE;
                     end else begin
                        end_in   = AW'(req_index);
                        issue_in = 1'b1;
                        state_in = ilide_pkg::ST_SCAN;
                     end
                  end
                  ilide_pkg::KIND_WRITE: begin
                     if (!in_range) begin
                        status_in = ilide_pkg::STATUS_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_index);
                        wr_data = req_value;
                     end
                  end
                  ilide_pkg::KIND_PUSH: begin
                     if (full) begin
                        status_in = ilide_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ilide_pkg::KIND_INSERT: begin
                     if (!in_range) begin
                        status_in = ilide_pkg::STATUS_RANGE;
                     end else if (full) begin
                        status_in = ilide_pkg::STATUS_FULL;
                     end else begin
                        ptr_in   = last_addr;
                        end_in   = AW'(req_index);
                        desc_in  = 1'b1;
                        issue_in = 1'b1;
                        state_in = ilide_pkg::ST_SCAN;
                     end
                  end
                  ilide_pkg::KIND_DELETE: begin
                     if (!in_range) begin
                        status_in = ilide_pkg::STATUS_RANGE;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ilide_pkg::ST_SCAN;
                     end
                  end
                  ilide_pkg::KIND_REMOVE, ilide_pkg::KIND_FIND: begin
                     ptr_in = '0;
                     if (count_ff == '0) begin
                        state_in = ilide_pkg::ST_FINISH;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ilide_pkg::ST_SCAN;
                     end
                  end
                  ilide_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = ilide_pkg::STATUS_EMPTY;
                     end else begin
                        idx_in   = last_addr;
                        ptr_in   = last_addr;
                        issue_in = 1'b1;
                        state_in = ilide_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = ilide_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         ilide_pkg::ST_SCAN: begin
            if (issue_ff) begin
               rd_en = 1'b1;
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end else if (desc_ff) begin
                  ptr_in = ptr_ff - AW'(1);
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
            pv_in    = issue_ff;
            paddr_in = ptr_ff;
            if (pv_ff) begin
               wr_data = rd_data;
               unique case (kind_ff)
                  ilide_pkg::KIND_READ, ilide_pkg::KIND_POP: begin
                     rdval_in = rd_data;
                  end
                  ilide_pkg::KIND_DELETE: begin
                     if (paddr_ff == idx_ff) begin
                        rdval_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = paddr_ff - AW'(1);
                     end
                  end
                  ilide_pkg::KIND_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = paddr_ff + AW'(1);
                  end
                  ilide_pkg::KIND_REMOVE: begin
                     if (rd_data != val_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(j_ff);
                        j_in    = j_ff + CW'(1);
                     end
                  end
                  ilide_pkg::KIND_FIND: begin
                     if (rd_data == val_ff) begin
                        found_in = ilide_pkg::FOUND_W'(paddr_ff);
                     end
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
               if (paddr_ff == end_ff) begin
                  pv_in    = 1'b0;
                  state_in = ilide_pkg::ST_FINISH;
               end
            end
         end

         ilide_pkg::ST_FINISH: begin
            unique case (kind_ff)
               ilide_pkg::KIND_INSERT: begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff;
                  wr_data  = val_ff;
                  count_in = count_ff + CW'(1);
               end
               ilide_pkg::KIND_REMOVE: begin
                  count_in = j_ff;
               end
               ilide_pkg::KIND_DELETE, ilide_pkg::KIND_POP: begin
                  count_in = count_ff - CW'(1);
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
            state_in = ilide_pkg::ST_DONE;
         end

         ilide_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ilide_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ilide_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall       = state_ff != ilide_pkg::ST_IDLE;
   assign rsp_valid       = state_ff == ilide_pkg::ST_DONE;
   assign rsp_read_value  = rdval_ff;
   assign rsp_found_index = found_ff;
   assign rsp_entry_count = ilide_pkg::COUNT_W'(count_ff);
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire
